// ===== rtl/core/pidsl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidsl_pkg
// Shared types and register codes for the slew-limited PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidsl_pkg;

	// Data and register-port geometry
	localparam int VAL_W   = 16;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 3;

	// Register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SLEW_STEP  = 3'd6;

	// Reset values of the configuration registers
	localparam logic [VAL_W-1:0] RST_SETPOINT   = 16'd0;
	localparam logic [VAL_W-1:0] RST_GAIN_P     = 16'd256;
	localparam logic [VAL_W-1:0] RST_GAIN_I     = 16'd0;
	localparam logic [VAL_W-1:0] RST_GAIN_D     = 16'd0;
	localparam logic [VAL_W-1:0] RST_LIMIT_HIGH = 16'd4080;
	localparam logic [VAL_W-1:0] RST_LIMIT_LOW  = 16'd0;
	localparam logic [VAL_W-1:0] RST_SLEW_STEP  = 16'd4080;

	// Configuration bundle from the register bank to the datapath
	typedef struct packed {
		logic signed [VAL_W-1:0] setpoint;
		logic [VAL_W-1:0]        gain_p;
		logic [VAL_W-1:0]        gain_i;
		logic [VAL_W-1:0]        gain_d;
		logic signed [VAL_W-1:0] limit_high;
		logic signed [VAL_W-1:0] limit_low;
		logic [VAL_W-1:0]        slew_step;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/pid_slew_limited_controller.sv =====
// Flow: a taken sample is held in the input register; its drive is loaded into
//   the result register once that register is free or draining, and is valid
//   from then until the downstream side takes it. Throughput: one sample per
//   cycle while drive_ready is high; output back-pressure stalls the input.
// Reset: arst_n clears the integrator, previous sample and previous drive to
//   zero and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
// pid_slew_limited_controller
// PID controller with derivative on measurement, integrator clamp, slew
// limit and output clamp; APB configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_slew_limited_controller import pidsl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_ready,
	input  wire logic signed [15:0] sample,
	output logic                    drive_valid,
	input  wire logic               drive_ready,
	output logic signed [15:0]      drive,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	cfg_t               cfg;
	logic               valid_s1;
	logic signed [15:0] sample_s1;
	logic signed [15:0] error_sum_q;
	logic signed [15:0] last_sample_q;
	logic signed [15:0] drive_q;
	logic               drive_valid_q;
	logic               fire;
	logic signed [15:0] error_sum_nxt;
	logic signed [15:0] drive_nxt;

	pidsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidsl_core u_core (
		.cfg           (cfg),
		.sample        (sample_s1),
		.error_sum     (error_sum_q),
		.last_sample   (last_sample_q),
		.last_drive    (drive_q),
		.error_sum_nxt (error_sum_nxt),
		.drive_nxt     (drive_nxt)
	);

	// Advance the held sample when the result register is free or draining
	assign fire         = valid_s1 & (~drive_valid_q | drive_ready);
	assign sample_ready = ~valid_s1 | fire;

	// Control and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			drive_valid_q <= 1'b0;
			error_sum_q   <= '0;
			last_sample_q <= '0;
			drive_q       <= '0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (fire) begin
				error_sum_q   <= error_sum_nxt;
				last_sample_q <= sample_s1;
				drive_q       <= drive_nxt;
				drive_valid_q <= 1'b1;
			end else if (drive_ready) begin
				drive_valid_q <= 1'b0;
			end
		end
	end

	// Capture the sample on each input transfer
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

	// A computed result always shows up in the result register
	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> drive_valid_q)
		else $error("result register not loaded after compute");

	// Integrator lands at a limit or between them
	a_integrator_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fire) |-> (error_sum_q == $past(cfg.limit_high)
			|| error_sum_q == $past(cfg.limit_low)
			|| (error_sum_q <= $past(cfg.limit_high)
				&& error_sum_q >= $past(cfg.limit_low))))
		else $error("integrator outside limits");

	// Drive lands at a limit or between them
	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fire) |-> (drive_q == $past(cfg.limit_high)
			|| drive_q == $past(cfg.limit_low)
			|| (drive_q <= $past(cfg.limit_high)
				&& drive_q >= $past(cfg.limit_low))))
		else $error("drive outside limits");

endmodule

`default_nettype wire

// ===== rtl/core/pidsl_regs.sv =====
// ----------------------------------------------------------------------------
// pidsl_regs
// APB register bank holding setpoint, gains, output limits and slew step.
// ----------------------------------------------------------------------------
`default_nettype none

module pidsl_regs import pidsl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [VAL_W-1:0]     wr_val;
	logic [VAL_W-1:0]     rd_val;
	cfg_t                 cfg_q;

	// Decode the access phase of a write transfer
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_val  = pwdata[VAL_W-1:0];

	// Update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint   <= RST_SETPOINT;
			cfg_q.gain_p     <= RST_GAIN_P;
			cfg_q.gain_i     <= RST_GAIN_I;
			cfg_q.gain_d     <= RST_GAIN_D;
			cfg_q.limit_high <= RST_LIMIT_HIGH;
			cfg_q.limit_low  <= RST_LIMIT_LOW;
			cfg_q.slew_step  <= RST_SLEW_STEP;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SETPOINT:   cfg_q.setpoint   <= wr_val;
				REG_GAIN_P:     cfg_q.gain_p     <= wr_val;
				REG_GAIN_I:     cfg_q.gain_i     <= wr_val;
				REG_GAIN_D:     cfg_q.gain_d     <= wr_val;
				REG_LIMIT_HIGH: cfg_q.limit_high <= wr_val;
				REG_LIMIT_LOW:  cfg_q.limit_low  <= wr_val;
				REG_SLEW_STEP:  cfg_q.slew_step  <= wr_val;
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			REG_SETPOINT:   rd_val = cfg_q.setpoint;
			REG_GAIN_P:     rd_val = cfg_q.gain_p;
			REG_GAIN_I:     rd_val = cfg_q.gain_i;
			REG_GAIN_D:     rd_val = cfg_q.gain_d;
			REG_LIMIT_HIGH: rd_val = cfg_q.limit_high;
			REG_LIMIT_LOW:  rd_val = cfg_q.limit_low;
			REG_SLEW_STEP:  rd_val = cfg_q.slew_step;
			default:        rd_val = '0;
		endcase
	end

	assign prdata = {{(PDATA_W-VAL_W){1'b0}}, rd_val};
	assign cfg    = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/pidsl_core.sv =====
// ----------------------------------------------------------------------------
// pidsl_core
// One-pass PID datapath: integrator update, three gain products, floor
// shift to Q12.4, saturation, slew limit and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pidsl_core import pidsl_pkg::*; (
	input  wire cfg_t                cfg,
	input  wire logic signed [15:0]  sample,
	input  wire logic signed [15:0]  error_sum,
	input  wire logic signed [15:0]  last_sample,
	input  wire logic signed [15:0]  last_drive,
	output logic signed [15:0]       error_sum_nxt,
	output logic signed [15:0]       drive_nxt
);

	localparam logic signed [27:0] SAT_HI = 28'sd32767;
	localparam logic signed [27:0] SAT_LO = -28'sd32768;

	logic signed [16:0] err;
	logic signed [16:0] dmeas;
	logic signed [17:0] sum_raw;
	logic signed [17:0] lim_hi;
	logic signed [17:0] lim_lo;
	logic signed [17:0] sum_clamp;
	logic signed [33:0] prod_p;
	logic signed [33:0] prod_i;
	logic signed [33:0] prod_d;
	logic signed [35:0] acc;
	logic signed [27:0] acc_q4;
	logic signed [15:0] drive_sat;
	logic signed [17:0] step_ext;
	logic signed [17:0] last_ext;
	logic signed [17:0] diff;
	logic signed [17:0] drive_slew;
	logic signed [17:0] drive_clamp;

	// Error and measurement change, exact at 17 bits
	assign err   = $signed({cfg.setpoint[15], cfg.setpoint}) - $signed({sample[15], sample});
	assign dmeas = $signed({sample[15], sample}) - $signed({last_sample[15], last_sample});

	// Integrator: add raw error, clamp high first then low
	assign lim_hi  = $signed({{2{cfg.limit_high[15]}}, cfg.limit_high});
	assign lim_lo  = $signed({{2{cfg.limit_low[15]}}, cfg.limit_low});
	assign sum_raw = $signed({{2{error_sum[15]}}, error_sum}) + $signed({err[16], err});

	always_comb begin
		if (sum_raw > lim_hi) begin
			sum_clamp = lim_hi;
		end else if (sum_raw < lim_lo) begin
			sum_clamp = lim_lo;
		end else begin
			sum_clamp = sum_raw;
		end
	end

	assign error_sum_nxt = sum_clamp[15:0];

	// Gain products in Q.12, summed exactly
	assign prod_p = 34'($signed({1'b0, cfg.gain_p})) * 34'(err);
	assign prod_i = 34'($signed({1'b0, cfg.gain_i}))
		* 34'($signed({error_sum_nxt[15], error_sum_nxt}));
	assign prod_d = 34'($signed({1'b0, cfg.gain_d})) * 34'(dmeas);
	assign acc    = 36'(prod_p) + 36'(prod_i) - 36'(prod_d);

	// Drop eight fraction bits (floor) and saturate to 16 bits
	assign acc_q4 = $signed(acc[35:8]);

	always_comb begin
		if (acc_q4 > SAT_HI) begin
			drive_sat = 16'sh7FFF;
		end else if (acc_q4 < SAT_LO) begin
			drive_sat = 16'sh8000;
		end else begin
			drive_sat = acc_q4[15:0];
		end
	end

	// Slew limit against the previous drive, at full width
	assign step_ext = $signed({2'b00, cfg.slew_step});
	assign last_ext = $signed({{2{last_drive[15]}}, last_drive});
	assign diff     = $signed({{2{drive_sat[15]}}, drive_sat}) - last_ext;

	always_comb begin
		if (diff > step_ext) begin
			drive_slew = last_ext + step_ext;
		end else if (diff < -step_ext) begin
			drive_slew = last_ext - step_ext;
		end else begin
			drive_slew = $signed({{2{drive_sat[15]}}, drive_sat});
		end
	end

	// Output clamp, high first then low
	always_comb begin
		if (drive_slew > lim_hi) begin
			drive_clamp = lim_hi;
		end else if (drive_slew < lim_lo) begin
			drive_clamp = lim_lo;
		end else begin
			drive_clamp = drive_slew;
		end
	end

	assign drive_nxt = drive_clamp[15:0];

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slew-limited PID controller. A local model of
// the integrator, PID sum, slew limit and output clamp predicts every drive
// value; the checker compares each drive transfer with the oldest prediction.
// Directed corner cases come first, then randomized traffic under several
// register settings and idling patterns, then a long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;
	import pidsl_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 11;
	localparam int CYCLE_LIMIT = 200000;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    sample_valid = 1'b0;
	logic                    sample_ready;
	logic signed [VAL_W-1:0] sample       = '0;
	logic                    drive_valid;
	logic                    drive_ready  = 1'b0;
	logic signed [VAL_W-1:0] drive;
	logic                    psel         = 1'b0;
	logic                    penable      = 1'b0;
	logic                    pwrite       = 1'b0;
	logic [PADDR_W-1:0]      paddr        = '0;
	logic [PDATA_W-1:0]      pwdata       = '0;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;

	// Controller settings as the model sees them
	logic signed [VAL_W-1:0] cfg_setpoint   = RST_SETPOINT;
	logic [VAL_W-1:0]        cfg_gain_p     = RST_GAIN_P;
	logic [VAL_W-1:0]        cfg_gain_i     = RST_GAIN_I;
	logic [VAL_W-1:0]        cfg_gain_d     = RST_GAIN_D;
	logic signed [VAL_W-1:0] cfg_limit_high = RST_LIMIT_HIGH;
	logic signed [VAL_W-1:0] cfg_limit_low  = RST_LIMIT_LOW;
	logic [VAL_W-1:0]        cfg_slew_step  = RST_SLEW_STEP;

	// Controller state as the model sees it
	logic signed [VAL_W-1:0] integ_sum   = '0;
	logic signed [VAL_W-1:0] prev_sample = '0;
	logic signed [VAL_W-1:0] prev_drive  = '0;

	logic signed [VAL_W-1:0] pending_drive[$];
	int                      mismatch_count     = 0;
	int                      cycle_count        = 0;
	int                      sender_gap_pct     = 29;
	int                      receiver_stall_pct = 72;
	int                      hold_off_left      = 0;

	pid_slew_limited_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.drive_valid  (drive_valid),
		.drive_ready  (drive_ready),
		.drive        (drive),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #CLK_HALF clk = ~clk;

	// Clamp to the output limits, upper limit tested first
	function automatic longint clamp_to_limits(input longint v);
		if (v > longint'(cfg_limit_high))
			return longint'(cfg_limit_high);
		if (v < longint'(cfg_limit_low))
			return longint'(cfg_limit_low);
		return v;
	endfunction

	// Advance the model by one sample and return the drive it yields
	function automatic logic signed [VAL_W-1:0] predict_drive(input logic signed [VAL_W-1:0] smp);
		longint err;
		longint dmeas;
		longint acc;
		longint drv;
		longint clamped;
		err     = longint'(cfg_setpoint) - longint'(smp);
		dmeas   = longint'(smp) - longint'(prev_sample);
		clamped = clamp_to_limits(longint'(integ_sum) + err);
		integ_sum = clamped[VAL_W-1:0];
		acc = longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * longint'(integ_sum)
			- longint'(cfg_gain_d) * dmeas;
		// Q.12 to Q12.4, floor
		drv = acc >>> 8;
		if (drv > 32767)
			drv = 32767;
		else if (drv < -32768)
			drv = -32768;
		// Slew limit against the previous drive
		if (drv - longint'(prev_drive) > longint'(cfg_slew_step))
			drv = longint'(prev_drive) + longint'(cfg_slew_step);
		else if (longint'(prev_drive) - drv > longint'(cfg_slew_step))
			drv = longint'(prev_drive) - longint'(cfg_slew_step);
		drv = clamp_to_limits(drv);
		prev_drive  = drv[VAL_W-1:0];
		prev_sample = smp;
		return drv[VAL_W-1:0];
	endfunction

	task automatic report_error(input string msg);
		mismatch_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles", CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Drive ready: long hold-off when requested, else random stalls
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			drive_ready <= 1'b0;
			hold_off_left <= hold_off_left - 1;
		end else begin
			drive_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Check each drive transfer against the oldest prediction
	always @(posedge clk) begin
		logic signed [VAL_W-1:0] want;
		if (arst_n && drive_valid && drive_ready) begin
			if (pending_drive.size() == 0) begin
				report_error($sformatf("drive %0d with no sample outstanding", drive));
			end else begin
				want = pending_drive.pop_front();
				if (drive !== want)
					report_error($sformatf("drive got %0d, want %0d", drive, want));
			end
		end
	end

	// One sample transfer; returns at the accepting edge with valid still high
	task automatic send_sample(input int val);
		logic signed [VAL_W-1:0] smp;
		smp = val[VAL_W-1:0];
		@(negedge clk);
		while ($urandom_range(99) < sender_gap_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= smp;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		pending_drive.push_back(predict_drive(smp));
	endtask

	// Drop valid and hold until every predicted drive has been taken
	task automatic wait_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// APB write: setup then access phase; psel stays high across back-to-back writes
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {{(PDATA_W-VAL_W){1'b0}}, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SETPOINT:   cfg_setpoint   = val;
			REG_GAIN_P:     cfg_gain_p     = val;
			REG_GAIN_I:     cfg_gain_i     = val;
			REG_GAIN_D:     cfg_gain_d     = val;
			REG_LIMIT_HIGH: cfg_limit_high = val;
			REG_LIMIT_LOW:  cfg_limit_low  = val;
			REG_SLEW_STEP:  cfg_slew_step  = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input int sp, input int kp, input int ki, input int kd,
			input int hi, input int lo, input int slew);
		wait_idle();
		write_reg(REG_SETPOINT,   sp[VAL_W-1:0]);
		write_reg(REG_GAIN_P,     kp[VAL_W-1:0]);
		write_reg(REG_GAIN_I,     ki[VAL_W-1:0]);
		write_reg(REG_GAIN_D,     kd[VAL_W-1:0]);
		write_reg(REG_LIMIT_HIGH, hi[VAL_W-1:0]);
		write_reg(REG_LIMIT_LOW,  lo[VAL_W-1:0]);
		write_reg(REG_SLEW_STEP,  slew[VAL_W-1:0]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic int rand_value();
		if ($urandom_range(1) == 0)
			return int'($urandom_range(0, 65535)) - 32768;
		return int'($urandom_range(0, 8000)) - 4000;
	endfunction

	function automatic int rand_gain();
		case ($urandom_range(4))
			0:       return 0;
			1:       return int'($urandom_range(0, 65535));
			default: return int'($urandom_range(0, 768));
		endcase
	endfunction

	// Mostly samples near the setpoint so the loop stays out of saturation
	function automatic int rand_sample();
		int v;
		if ($urandom_range(3) == 0)
			return int'($urandom_range(0, 65535)) - 32768;
		v = int'($urandom_range(0, 96)) - 48 + int'(cfg_setpoint);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	task automatic rand_config();
		int a;
		int b;
		int t;
		int slew;
		a = rand_value();
		b = rand_value();
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		case ($urandom_range(3))
			0:       slew = 65535;
			1:       slew = int'($urandom_range(0, 64));
			2:       slew = int'($urandom_range(0, 65535));
			default: slew = int'($urandom_range(0, 2000));
		endcase
		// Now and then cross the limits
		if ($urandom_range(5) == 0)
			set_config(rand_value(), rand_gain(), rand_gain(), rand_gain(), a, b, slew);
		else
			set_config(rand_value(), rand_gain(), rand_gain(), rand_gain(), b, a, slew);
	endtask

	// Reset values of the registers, no write yet
	task automatic test_reset_values();
		send_sample(0);
		send_sample(-16);
		send_sample(-32768);
		send_sample(16);
	endtask

	task automatic test_corner_cases();
		// Full-scale gains and error: saturate both ways
		set_config(32767, 65535, 65535, 65535, 32767, -32768, 65535);
		send_sample(-32768);
		send_sample(32767);
		send_sample(-32768);
		// Zero slew step: drive frozen
		set_config(-32768, 65535, 0, 0, 32767, -32768, 0);
		send_sample(32767);
		send_sample(-32768);
		// Crossed limits
		set_config(0, 256, 0, 0, -100, 100, 65535);
		send_sample(-500);
		send_sample(500);
		send_sample(0);
		// Small slew step with a high proportional gain
		set_config(0, 4096, 0, 0, 32767, -32768, 16);
		send_sample(-1000);
		send_sample(-1000);
		send_sample(1000);
		send_sample(1000);
		// Integrator clamp at both limits
		set_config(0, 0, 256, 0, 160, -160, 65535);
		send_sample(-100);
		send_sample(-100);
		send_sample(-100);
		send_sample(300);
		send_sample(300);
		// Derivative on measurement only
		set_config(0, 0, 0, 512, 32767, -32768, 65535);
		send_sample(0);
		send_sample(1000);
		send_sample(-1000);
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct,
			input int n_sets, input int per_set);
		sender_gap_pct     = gap_pct;
		receiver_stall_pct = stall_pct;
		for (int s = 0; s < n_sets; s++) begin
			rand_config();
			for (int i = 0; i < per_set; i++)
				send_sample(rand_sample());
		end
	endtask

	// Hold drive_ready low while samples keep coming, then pause until drained
	task automatic test_output_backpressure();
		rand_config();
		sender_gap_pct     = 0;
		receiver_stall_pct = 0;
		hold_off_left      = 80;
		repeat (12) send_sample(rand_sample());
		wait_idle();
	endtask

	initial begin
		repeat (RESET_CYC) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_corner_cases();
		test_random_traffic(29, 72, 3, 55);
		test_random_traffic(72, 29, 3, 55);
		test_random_traffic(0, 0, 3, 55);
		test_output_backpressure();

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pidsl_pkg.sv
rtl/core/pidsl_regs.sv
rtl/core/pidsl_core.sv
rtl/core/pid_slew_limited_controller.sv
verif/tb_top.sv
